// File: sv/vrr_pkg.sv
// Package for the vortex Rodrigues rotation core.
// Holds fixed-point constants, register codes, pipeline types and the CORDIC arctangent table.
// No dependencies.
package vrr_pkg;

  localparam logic signed [33:0] ONE_Q30         = 34'sd1073741824;
  localparam logic signed [33:0] HALF_TURN       = 34'sd2147483648;
  localparam logic signed [33:0] CORDIC_INV_GAIN = 34'sd652032874;
  localparam logic [29:0]        INV_TWO_PI_Q32  = 30'd683565276;
  localparam int                 ROT_DEPTH       = 7;

  typedef enum logic [2:0] {
    REG_CENTER_X  = 3'd0,
    REG_CENTER_Y  = 3'd1,
    REG_CENTER_Z  = 3'd2,
    REG_AXIS_X    = 3'd3,
    REG_AXIS_Y    = 3'd4,
    REG_AXIS_Z    = 3'd5,
    REG_TIME_STEP = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic signed [32:0] px;
    logic signed [32:0] py;
    logic signed [32:0] pz;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] vz;
  } prt_t;

  typedef struct packed {
    logic               vld;
    logic               flip;
    logic signed [33:0] x;
    logic signed [33:0] y;
    logic signed [33:0] z;
    prt_t               prt;
  } cord_t;

  function automatic logic [31:0] atan_turn(input logic [4:0] idx);
    logic [31:0] a;
    case (idx)
      5'd0:  a = 32'h20000000;
      5'd1:  a = 32'h12E4051E;
      5'd2:  a = 32'h09FB385B;
      5'd3:  a = 32'h051111D4;
      5'd4:  a = 32'h028B0D43;
      5'd5:  a = 32'h0145D7E1;
      5'd6:  a = 32'h00A2F61E;
      5'd7:  a = 32'h00517C55;
      5'd8:  a = 32'h0028BE53;
      5'd9:  a = 32'h00145F2F;
      5'd10: a = 32'h000A2F98;
      5'd11: a = 32'h000517CC;
      5'd12: a = 32'h00028BE6;
      5'd13: a = 32'h000145F3;
      5'd14: a = 32'h0000A2FA;
      5'd15: a = 32'h0000517D;
      5'd16: a = 32'h000028BE;
      5'd17: a = 32'h0000145F;
      5'd18: a = 32'h00000A30;
      5'd19: a = 32'h00000518;
      5'd20: a = 32'h0000028C;
      5'd21: a = 32'h00000146;
      5'd22: a = 32'h000000A3;
      5'd23: a = 32'h00000051;
      5'd24: a = 32'h00000029;
      5'd25: a = 32'h00000014;
      5'd26: a = 32'h0000000A;
      5'd27: a = 32'h00000005;
      5'd28: a = 32'h00000003;
      5'd29: a = 32'h00000001;
      5'd30: a = 32'h00000001;
      default: a = 32'h00000000;
    endcase
    return a;
  endfunction

endpackage

// File: sv/vrr_in_if.sv
// Input channel of the vortex rotation core: one particle per item.
// Depends on nothing.
interface vrr_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] pos_z;
  logic signed [31:0] vel_x;
  logic signed [31:0] vel_y;
  logic signed [31:0] vel_z;
  logic signed [23:0] spin_rate;

  modport source (output valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, spin_rate,
                  input ready);
  modport sink   (input valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, spin_rate,
                  output ready);
endinterface

// File: sv/vrr_out_if.sv
// Result channel of the vortex rotation core: rotated position and velocity.
// Depends on nothing.
interface vrr_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] new_pos_x;
  logic signed [31:0] new_pos_y;
  logic signed [31:0] new_pos_z;
  logic signed [31:0] new_vel_x;
  logic signed [31:0] new_vel_y;
  logic signed [31:0] new_vel_z;

  modport source (output valid, new_pos_x, new_pos_y, new_pos_z, new_vel_x, new_vel_y,
                  new_vel_z, input ready);
  modport sink   (input valid, new_pos_x, new_pos_y, new_pos_z, new_vel_x, new_vel_y,
                  new_vel_z, output ready);
endinterface

// File: sv/vrr_cell.sv
// One CORDIC rotation cell: a single micro-rotation, registered, carrying the particle along.
// Depends on vrr_pkg.
module vrr_cell #(
  parameter int IDX = 0
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  vrr_pkg::cord_t d_i,
  output vrr_pkg::cord_t q_o
);

  vrr_pkg::cord_t     cell_r;
  vrr_pkg::cord_t     cell_nxt;
  logic signed [33:0] xs;
  logic signed [33:0] ys;
  logic signed [33:0] at;

  always_comb begin
    xs = d_i.x >>> IDX;
    ys = d_i.y >>> IDX;
    at = 34'(vrr_pkg::atan_turn(5'(IDX)));
    cell_nxt = d_i;
    if (!d_i.z[33]) begin
      cell_nxt.x = d_i.x - ys;
      cell_nxt.y = d_i.y + xs;
      cell_nxt.z = d_i.z - at;
    end else begin
      cell_nxt.x = d_i.x + ys;
      cell_nxt.y = d_i.y - xs;
      cell_nxt.z = d_i.z + at;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_r.vld <= 1'b0;
    end else if (en) begin
      cell_r <= cell_nxt;
    end
  end

  assign q_o = cell_r;

endmodule

// File: sv/vrr_rot.sv
// Rodrigues rotation datapath for one vector: v*c + (k x v)*s + k*(k.v)*(1-c).
// Seven register stages, wide products split into halves. Depends on nothing outside.
module vrr_rot (
  input  logic               clk,
  input  logic               en,
  input  logic signed [32:0] v_i    [3],
  input  logic signed [31:0] k_i    [3],
  input  logic [30:0]        kmag_i [3],
  input  logic               kneg_i [3],
  input  logic signed [31:0] c_i,
  input  logic signed [31:0] s_i,
  input  logic [31:0]        omc_i,
  output logic signed [37:0] r_o    [3]
);

  logic [32:0] vm [3];
  logic        vn [3];
  logic [30:0] cm;
  logic [30:0] sm;

  logic signed [63:0] s1_pa_r  [3];
  logic signed [63:0] s1_pb_r  [3];
  logic [63:0]        s1_kvm_r [3];
  logic               s1_kvn_r [3];
  logic [63:0]        s1_vcm_r [3];
  logic               s1_vcn_r [3];
  logic [30:0]        s1_sm_r;
  logic               s1_sn_r;
  logic [31:0]        s1_omc_r;

  logic signed [63:0] s2_cr_r [3];
  logic signed [51:0] s2_d_r;
  logic signed [34:0] s2_vc_r [3];
  logic [30:0]        s2_sm_r;
  logic               s2_sn_r;
  logic [31:0]        s2_omc_r;

  logic [63:0]        s3_crm_r [3];
  logic               s3_crsn_r [3];
  logic [51:0]        s3_dm_r;
  logic               s3_dn_r;
  logic signed [34:0] s3_vc_r [3];
  logic [30:0]        s3_sm_r;
  logic [31:0]        s3_omc_r;

  logic [62:0]        s4_clo_r [3];
  logic [62:0]        s4_chi_r [3];
  logic               s4_cn_r  [3];
  logic [57:0]        s4_elo_r;
  logic [57:0]        s4_ehi_r;
  logic               s4_en_r;
  logic signed [34:0] s4_vc_r [3];

  logic [94:0]        crs_full [3];
  logic [83:0]        e_full;
  logic signed [35:0] s5_crs_r [3];
  logic [51:0]        s5_em_r;
  logic               s5_en_r;
  logic signed [34:0] s5_vc_r [3];

  logic [56:0]        s6_klo_r [3];
  logic [56:0]        s6_khi_r [3];
  logic               s6_kn_r  [3];
  logic signed [35:0] s6_crs_r [3];
  logic signed [34:0] s6_vc_r  [3];

  logic [82:0]        ke_full [3];
  logic signed [37:0] ke      [3];
  logic signed [37:0] r_r     [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      vn[i] = v_i[i][32];
      vm[i] = vn[i] ? 33'(-v_i[i]) : 33'(v_i[i]);
    end
    cm = c_i[31] ? 31'(-c_i) : 31'(c_i);
    sm = s_i[31] ? 31'(-s_i) : 31'(s_i);
  end

  // cross products, dot terms, cosine terms
  always_ff @(posedge clk) begin
    if (en) begin
      s1_pa_r[0] <= 64'(k_i[1]) * 64'(v_i[2]);
      s1_pb_r[0] <= 64'(k_i[2]) * 64'(v_i[1]);
      s1_pa_r[1] <= 64'(k_i[2]) * 64'(v_i[0]);
      s1_pb_r[1] <= 64'(k_i[0]) * 64'(v_i[2]);
      s1_pa_r[2] <= 64'(k_i[0]) * 64'(v_i[1]);
      s1_pb_r[2] <= 64'(k_i[1]) * 64'(v_i[0]);
      for (int i = 0; i < 3; i++) begin
        s1_kvm_r[i] <= 64'(kmag_i[i]) * 64'(vm[i]);
        s1_kvn_r[i] <= kneg_i[i] ^ vn[i];
        s1_vcm_r[i] <= 64'(vm[i]) * 64'(cm);
        s1_vcn_r[i] <= vn[i] ^ c_i[31];
      end
      s1_sm_r  <= sm;
      s1_sn_r  <= s_i[31];
      s1_omc_r <= omc_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_d_r <= (s1_kvn_r[0] ? -52'(s1_kvm_r[0][63:14]) : 52'(s1_kvm_r[0][63:14]))
              + (s1_kvn_r[1] ? -52'(s1_kvm_r[1][63:14]) : 52'(s1_kvm_r[1][63:14]))
              + (s1_kvn_r[2] ? -52'(s1_kvm_r[2][63:14]) : 52'(s1_kvm_r[2][63:14]));
      for (int i = 0; i < 3; i++) begin
        s2_cr_r[i] <= s1_pa_r[i] - s1_pb_r[i];
        s2_vc_r[i] <= s1_vcn_r[i] ? -35'(s1_vcm_r[i][63:30]) : 35'(s1_vcm_r[i][63:30]);
      end
      s2_sm_r  <= s1_sm_r;
      s2_sn_r  <= s1_sn_r;
      s2_omc_r <= s1_omc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s3_crm_r[i]  <= s2_cr_r[i][63] ? 64'(-s2_cr_r[i]) : 64'(s2_cr_r[i]);
        s3_crsn_r[i] <= s2_cr_r[i][63] ^ s2_sn_r;
        s3_vc_r[i]   <= s2_vc_r[i];
      end
      s3_dm_r  <= s2_d_r[51] ? 52'(-s2_d_r) : 52'(s2_d_r);
      s3_dn_r  <= s2_d_r[51];
      s3_sm_r  <= s2_sm_r;
      s3_omc_r <= s2_omc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s4_clo_r[i] <= 63'(s3_crm_r[i][31:0]) * 63'(s3_sm_r);
        s4_chi_r[i] <= 63'(s3_crm_r[i][63:32]) * 63'(s3_sm_r);
        s4_cn_r[i]  <= s3_crsn_r[i];
        s4_vc_r[i]  <= s3_vc_r[i];
      end
      s4_elo_r <= 58'(s3_dm_r[25:0]) * 58'(s3_omc_r);
      s4_ehi_r <= 58'(s3_dm_r[51:26]) * 58'(s3_omc_r);
      s4_en_r  <= s3_dn_r;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      crs_full[i] = {s4_chi_r[i], 32'd0} + 95'(s4_clo_r[i]);
    end
    e_full = {s4_ehi_r, 26'd0} + 84'(s4_elo_r);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s5_crs_r[i] <= s4_cn_r[i] ? -36'(crs_full[i][94:60]) : 36'(crs_full[i][94:60]);
        s5_vc_r[i]  <= s4_vc_r[i];
      end
      s5_em_r <= e_full[81:30];
      s5_en_r <= s4_en_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s6_klo_r[i] <= 57'(kmag_i[i]) * 57'(s5_em_r[25:0]);
        s6_khi_r[i] <= 57'(kmag_i[i]) * 57'(s5_em_r[51:26]);
        s6_kn_r[i]  <= kneg_i[i] ^ s5_en_r;
        s6_crs_r[i] <= s5_crs_r[i];
        s6_vc_r[i]  <= s5_vc_r[i];
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ke_full[i] = {s6_khi_r[i], 26'd0} + 83'(s6_klo_r[i]);
      ke[i] = s6_kn_r[i] ? -38'(ke_full[i][82:46]) : 38'(ke_full[i][82:46]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        r_r[i] <= 38'(s6_vc_r[i]) + 38'(s6_crs_r[i]) + ke[i];
      end
    end
  end

  assign r_o = r_r;

endmodule

// File: sv/vortex_rodrigues_rotate_core.sv
// Vortex rotation core: phase from rate and time step, CORDIC cell chain, Rodrigues rotation.
// One item per cycle; the whole pipe holds while the result register is full and not taken.
// Phase multiply, each CORDIC cell and each split product set the stage count. Reset clears all
// valid bits and loads register defaults (axis = +Z, everything else zero). Depends on vrr_pkg,
// vrr_in_if, vrr_out_if, vrr_cell, vrr_rot.
module vortex_rodrigues_rotate_core #(
  parameter int CORDIC_STAGES = 24
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_idx,
  input  logic [31:0] cfg_wdata,
  vrr_in_if.sink      in_ch,
  vrr_out_if.source   out_ch
);

  localparam int RD = vrr_pkg::ROT_DEPTH;

  logic signed [31:0] ctr_r  [3];
  logic signed [31:0] axis_r [3];
  logic [24:0]        ts_r;

  logic signed [31:0] kc_r   [3];
  logic [30:0]        kmag_r [3];
  logic               kneg_r [3];
  logic signed [31:0] kc_nxt [3];

  logic en;

  logic               a_vld_r;
  logic               a_neg_r;
  logic [47:0]        a_mag_r;
  vrr_pkg::prt_t      a_prt_r;
  logic [23:0]        rmag;
  vrr_pkg::prt_t      a_prt_nxt;

  logic               b_vld_r;
  logic               b_neg_r;
  logic [53:0]        b_hi_r;
  logic [53:0]        b_lo_r;
  vrr_pkg::prt_t      b_prt_r;

  logic [54:0]        c_sum;
  logic [31:0]        c_ph;
  logic signed [33:0] c_z;
  logic               c_flip;
  vrr_pkg::cord_t     cord0_r;
  vrr_pkg::cord_t     cord0_nxt;
  vrr_pkg::cord_t     chain [CORDIC_STAGES+1];

  logic signed [33:0] xf;
  logic signed [33:0] yf;
  logic signed [33:0] cc;
  logic signed [33:0] sc;
  logic               d_vld_r;
  logic signed [31:0] d_c_r;
  logic signed [31:0] d_s_r;
  logic [31:0]        d_omc_r;
  vrr_pkg::prt_t      d_prt_r;

  logic signed [32:0] pv [3];
  logic signed [32:0] vv [3];
  logic signed [37:0] rp [3];
  logic signed [37:0] rv [3];
  logic [RD-1:0]      r_vld_r;

  logic               out_valid_r;
  logic signed [31:0] np_r [3];
  logic signed [31:0] nv_r [3];

  function automatic logic signed [31:0] sat32(input logic signed [38:0] v);
    logic signed [31:0] r;
    if (v > 39'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -39'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = 32'(v);
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctr_r[0]  <= '0;
      ctr_r[1]  <= '0;
      ctr_r[2]  <= '0;
      axis_r[0] <= '0;
      axis_r[1] <= '0;
      axis_r[2] <= 32'(vrr_pkg::ONE_Q30);
      ts_r      <= '0;
    end else if (cfg_we) begin
      case (vrr_pkg::cfg_reg_t'(cfg_idx))
        vrr_pkg::REG_CENTER_X:  ctr_r[0]  <= cfg_wdata;
        vrr_pkg::REG_CENTER_Y:  ctr_r[1]  <= cfg_wdata;
        vrr_pkg::REG_CENTER_Z:  ctr_r[2]  <= cfg_wdata;
        vrr_pkg::REG_AXIS_X:    axis_r[0] <= cfg_wdata;
        vrr_pkg::REG_AXIS_Y:    axis_r[1] <= cfg_wdata;
        vrr_pkg::REG_AXIS_Z:    axis_r[2] <= cfg_wdata;
        vrr_pkg::REG_TIME_STEP: ts_r      <= cfg_wdata[24:0];
        default: ;
      endcase
    end
  end

  // clamp axis to unit range
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (34'(axis_r[i]) > vrr_pkg::ONE_Q30) begin
        kc_nxt[i] = 32'(vrr_pkg::ONE_Q30);
      end else if (34'(axis_r[i]) < -vrr_pkg::ONE_Q30) begin
        kc_nxt[i] = 32'(-vrr_pkg::ONE_Q30);
      end else begin
        kc_nxt[i] = axis_r[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      kc_r[i]   <= kc_nxt[i];
      kmag_r[i] <= kc_nxt[i][31] ? 31'(-kc_nxt[i]) : 31'(kc_nxt[i]);
      kneg_r[i] <= kc_nxt[i][31];
    end
  end

  assign en = !out_valid_r || out_ch.ready;
  assign in_ch.ready = en && rst_n;

  always_comb begin
    rmag = in_ch.spin_rate[23] ? 24'(-in_ch.spin_rate) : 24'(in_ch.spin_rate);
    a_prt_nxt.px = 33'(in_ch.pos_x) - 33'(ctr_r[0]);
    a_prt_nxt.py = 33'(in_ch.pos_y) - 33'(ctr_r[1]);
    a_prt_nxt.pz = 33'(in_ch.pos_z) - 33'(ctr_r[2]);
    a_prt_nxt.vx = in_ch.vel_x;
    a_prt_nxt.vy = in_ch.vel_y;
    a_prt_nxt.vz = in_ch.vel_z;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
    end else if (en) begin
      a_vld_r <= in_ch.valid;
      b_vld_r <= a_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_neg_r <= in_ch.spin_rate[23];
      a_mag_r <= 48'(rmag) * 48'(ts_r);
      a_prt_r <= a_prt_nxt;
      b_neg_r <= a_neg_r;
      b_hi_r  <= 54'(a_mag_r[47:24]) * 54'(vrr_pkg::INV_TWO_PI_Q32);
      b_lo_r  <= 54'(a_mag_r[23:0]) * 54'(vrr_pkg::INV_TWO_PI_Q32);
      b_prt_r <= a_prt_r;
    end
  end

  // phase in turns, fold to a quarter turn
  always_comb begin
    c_sum  = 55'(b_hi_r) + 55'(b_lo_r[53:24]);
    c_ph   = b_neg_r ? (32'd0 - c_sum[47:16]) : c_sum[47:16];
    c_z    = 34'($signed(c_ph));
    c_flip = 1'b0;
    if (c_z > vrr_pkg::ONE_Q30) begin
      c_z    = c_z - vrr_pkg::HALF_TURN;
      c_flip = 1'b1;
    end else if (c_z < -vrr_pkg::ONE_Q30) begin
      c_z    = c_z + vrr_pkg::HALF_TURN;
      c_flip = 1'b1;
    end
    cord0_nxt.vld  = b_vld_r;
    cord0_nxt.flip = c_flip;
    cord0_nxt.x    = vrr_pkg::CORDIC_INV_GAIN;
    cord0_nxt.y    = '0;
    cord0_nxt.z    = c_z;
    cord0_nxt.prt  = b_prt_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cord0_r.vld <= 1'b0;
    end else if (en) begin
      cord0_r <= cord0_nxt;
    end
  end

  assign chain[0] = cord0_r;

  for (genvar g = 0; g < CORDIC_STAGES; g++) begin : g_cell
    vrr_cell #(.IDX(g)) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .d_i   (chain[g]),
      .q_o   (chain[g+1])
    );
  end

  always_comb begin
    xf = chain[CORDIC_STAGES].flip ? -chain[CORDIC_STAGES].x : chain[CORDIC_STAGES].x;
    yf = chain[CORDIC_STAGES].flip ? -chain[CORDIC_STAGES].y : chain[CORDIC_STAGES].y;
    cc = (xf > vrr_pkg::ONE_Q30) ? vrr_pkg::ONE_Q30 :
         (xf < -vrr_pkg::ONE_Q30) ? -vrr_pkg::ONE_Q30 : xf;
    sc = (yf > vrr_pkg::ONE_Q30) ? vrr_pkg::ONE_Q30 :
         (yf < -vrr_pkg::ONE_Q30) ? -vrr_pkg::ONE_Q30 : yf;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_vld_r     <= 1'b0;
      r_vld_r     <= '0;
      out_valid_r <= 1'b0;
    end else if (en) begin
      d_vld_r     <= chain[CORDIC_STAGES].vld;
      r_vld_r     <= {r_vld_r[RD-2:0], d_vld_r};
      out_valid_r <= r_vld_r[RD-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_c_r   <= 32'(cc);
      d_s_r   <= 32'(sc);
      d_omc_r <= 32'(vrr_pkg::ONE_Q30 - cc);
      d_prt_r <= chain[CORDIC_STAGES].prt;
    end
  end

  always_comb begin
    pv[0] = d_prt_r.px;
    pv[1] = d_prt_r.py;
    pv[2] = d_prt_r.pz;
    vv[0] = 33'(d_prt_r.vx);
    vv[1] = 33'(d_prt_r.vy);
    vv[2] = 33'(d_prt_r.vz);
  end

  vrr_rot u_rot_pos (
    .clk    (clk),
    .en     (en),
    .v_i    (pv),
    .k_i    (kc_r),
    .kmag_i (kmag_r),
    .kneg_i (kneg_r),
    .c_i    (d_c_r),
    .s_i    (d_s_r),
    .omc_i  (d_omc_r),
    .r_o    (rp)
  );

  vrr_rot u_rot_vel (
    .clk    (clk),
    .en     (en),
    .v_i    (vv),
    .k_i    (kc_r),
    .kmag_i (kmag_r),
    .kneg_i (kneg_r),
    .c_i    (d_c_r),
    .s_i    (d_s_r),
    .omc_i  (d_omc_r),
    .r_o    (rv)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        np_r[i] <= sat32(39'(rp[i]) + 39'(ctr_r[i]));
        nv_r[i] <= sat32(39'(rv[i]));
      end
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.new_pos_x = np_r[0];
  assign out_ch.new_pos_y = np_r[1];
  assign out_ch.new_pos_z = np_r[2];
  assign out_ch.new_vel_x = nv_r[0];
  assign out_ch.new_vel_y = nv_r[1];
  assign out_ch.new_vel_z = nv_r[2];

  a_stall_hold : assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(r_vld_r) && $stable(d_vld_r))
    else $error("pipe valid bits moved during stall");

  a_fold_range : assert property (@(posedge clk) disable iff (!rst_n)
    cord0_r.vld |-> (cord0_r.z <= vrr_pkg::ONE_Q30) && (cord0_r.z >= -vrr_pkg::ONE_Q30))
    else $error("folded phase outside quarter turn");

  a_cos_range : assert property (@(posedge clk) disable iff (!rst_n)
    d_vld_r |-> (34'(d_c_r) <= vrr_pkg::ONE_Q30) && (34'(d_c_r) >= -vrr_pkg::ONE_Q30)
      && (34'(d_s_r) <= vrr_pkg::ONE_Q30) && (34'(d_s_r) >= -vrr_pkg::ONE_Q30))
    else $error("cosine or sine out of range");

  a_out_load : assert property (@(posedge clk) disable iff (!rst_n)
    en && r_vld_r[RD-1] |=> out_valid_r)
    else $error("finished item not loaded into result register");

endmodule
